// ===== hw/rtl/uvtg_pkg.sv =====
// shared types and constants for the time-based uuid generator
`default_nettype none

package uvtg_pkg;

    localparam int CLOCK_W    = 60;
    localparam int RND_W      = 16;
    localparam int NODE_W     = 48;
    localparam int TICK_W     = 24;
    localparam int STAMP_W    = 64;
    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 4;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 128;

    localparam logic [TICK_W-1:0] MAX_PER_TICK_RESET = 24'd10000000;

    // register index, taken from paddr bit 3 (registers sit at 8-byte steps)
    localparam logic REG_NODE_ID      = 1'b0;
    localparam logic REG_MAX_PER_TICK = 1'b1;

    localparam logic [3:0] UUID_VERSION = 4'h1;
    localparam logic [1:0] UUID_VARIANT = 2'b10;

    typedef struct packed {
        logic [NODE_W-1:0] node_id;
        logic [TICK_W-1:0] max_per_tick;
    } cfg_t;

    typedef struct packed {
        logic        issued;
        logic [31:0] time_low;
        logic [15:0] time_mid;
        logic [15:0] time_high_version;
        logic [7:0]  clock_seq_high_variant;
        logic [7:0]  clock_seq_low;
        logic [NODE_W-1:0] node_out;
    } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/uvtg_cfg_regs.sv =====
// apb configuration registers: node id and per-tick limit
`default_nettype none

module uvtg_cfg_regs (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [uvtg_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [uvtg_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [uvtg_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready,
    output uvtg_pkg::cfg_t                         cfg
);

    logic [uvtg_pkg::NODE_W-1:0] node_id_reg;
    logic [uvtg_pkg::TICK_W-1:0] max_per_tick_reg;
    logic                        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_id_reg      <= '0;
            max_per_tick_reg <= uvtg_pkg::MAX_PER_TICK_RESET;
        end
        else if (wr_en)
        begin
            case (paddr[3])
                uvtg_pkg::REG_NODE_ID:
                begin
                    node_id_reg <= pwdata[uvtg_pkg::NODE_W-1:0];
                end
                uvtg_pkg::REG_MAX_PER_TICK:
                begin
                    max_per_tick_reg <= pwdata[uvtg_pkg::TICK_W-1:0];
                end
                default:
                begin
                    node_id_reg <= node_id_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3])
            uvtg_pkg::REG_NODE_ID:
            begin
                prdata = {{(uvtg_pkg::APB_DATA_W-uvtg_pkg::NODE_W){1'b0}}, node_id_reg};
            end
            uvtg_pkg::REG_MAX_PER_TICK:
            begin
                prdata = {{(uvtg_pkg::APB_DATA_W-uvtg_pkg::TICK_W){1'b0}}, max_per_tick_reg};
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    assign cfg.node_id      = node_id_reg;
    assign cfg.max_per_tick = max_per_tick_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/uvtg_engine.sv =====
// generator state and the combinational uuid computation
`default_nettype none

module uvtg_engine (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             fire,
    input  wire logic [uvtg_pkg::CLOCK_W-1:0]     clock_now,
    input  wire logic [uvtg_pkg::RND_W-1:0]       random_seq,
    input  wire uvtg_pkg::cfg_t                   cfg,
    output uvtg_pkg::result_t                     result
);

    logic                          primed_reg;
    logic [uvtg_pkg::CLOCK_W-1:0]  last_clock_reg;
    logic [uvtg_pkg::TICK_W-1:0]   tick_count_reg;
    logic                          have_saved_reg;
    logic [uvtg_pkg::STAMP_W-1:0]  saved_stamp_reg;
    logic [uvtg_pkg::RND_W-1:0]    saved_sequence_reg;
    logic [uvtg_pkg::NODE_W-1:0]   saved_node_reg;

    logic                          same_tick;
    logic                          saturated;
    logic                          refuse;
    logic [uvtg_pkg::TICK_W-1:0]   tick_count_next;
    logic [uvtg_pkg::STAMP_W-1:0]  stamp;
    logic [uvtg_pkg::RND_W-1:0]    seq;

    assign same_tick       = (clock_now == last_clock_reg);
    assign saturated       = same_tick && !(tick_count_reg < cfg.max_per_tick);
    assign refuse          = !primed_reg || saturated;
    assign tick_count_next = same_tick ? tick_count_reg + 1'b1 : '0;
    assign stamp = {{(uvtg_pkg::STAMP_W-uvtg_pkg::CLOCK_W){1'b0}}, clock_now}
                 + {{(uvtg_pkg::STAMP_W-uvtg_pkg::TICK_W){1'b0}}, tick_count_next};

    always_comb
    begin
        if (!have_saved_reg || (saved_node_reg != cfg.node_id))
        begin
            seq = random_seq;
        end
        else if (stamp < saved_stamp_reg)
        begin
            // time ran backwards
            seq = saved_sequence_reg + 1'b1;
        end
        else
        begin
            seq = saved_sequence_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg         <= 1'b0;
            last_clock_reg     <= '0;
            tick_count_reg     <= '0;
            have_saved_reg     <= 1'b0;
            saved_stamp_reg    <= '0;
            saved_sequence_reg <= '0;
            saved_node_reg     <= '0;
        end
        else if (fire)
        begin
            if (!primed_reg)
            begin
                // first item only primes the count
                primed_reg     <= 1'b1;
                last_clock_reg <= clock_now;
                tick_count_reg <= cfg.max_per_tick;
            end
            else if (!saturated)
            begin
                last_clock_reg     <= clock_now;
                tick_count_reg     <= tick_count_next;
                have_saved_reg     <= 1'b1;
                saved_stamp_reg    <= stamp;
                saved_sequence_reg <= seq;
                saved_node_reg     <= cfg.node_id;
            end
        end
    end

    always_comb
    begin
        result = '0;
        if (!refuse)
        begin
            result.issued                 = 1'b1;
            result.time_low               = stamp[31:0];
            result.time_mid               = stamp[47:32];
            result.time_high_version      = {uvtg_pkg::UUID_VERSION, stamp[59:48]};
            result.clock_seq_high_variant = {uvtg_pkg::UUID_VARIANT, seq[13:8]};
            result.clock_seq_low          = seq[7:0];
            result.node_out               = cfg.node_id;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/uuid_v1_time_generator_core.sv =====
// top level: input register, uuid engine, output register, apb registers
// result path: the input reg takes the item on accept, then the result reg captures it on advance
// throughput: one item per cycle unless the output stalls on m_tready
// a result waiting on m_tready does not block one further item entering the input reg
// reset (rst_n, async, active low): pipeline empties, generator unprimed,
// node_id 0, max_per_tick 10000000
`default_nettype none

module uuid_v1_time_generator_core (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // clock_now [59:0], random_seq [75:60]
    input  wire logic [uvtg_pkg::IN_DATA_W-1:0]     s_tdata,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // time_low [31:0], time_mid [47:32], time_high_version [63:48],
    // clock_seq_high_variant [71:64], clock_seq_low [79:72], node_out [127:80]
    output logic      [uvtg_pkg::OUT_DATA_W-1:0]    m_tdata,
    // issued [0]
    output logic                                    m_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [uvtg_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [uvtg_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [uvtg_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                    pready
);

    uvtg_pkg::cfg_t                 cfg;
    uvtg_pkg::result_t              result;

    logic                           in_valid_reg;
    logic [uvtg_pkg::CLOCK_W-1:0]   in_clock_reg;
    logic [uvtg_pkg::RND_W-1:0]     in_rnd_reg;
    logic                           out_valid_reg;
    uvtg_pkg::result_t              out_result_reg;
    logic                           advance;
    logic                           in_take;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    uvtg_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    uvtg_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (advance),
        .clock_now  (in_clock_reg),
        .random_seq (in_rnd_reg),
        .cfg        (cfg),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_clock_reg <= s_tdata[uvtg_pkg::CLOCK_W-1:0];
            in_rnd_reg   <= s_tdata[uvtg_pkg::CLOCK_W+uvtg_pkg::RND_W-1:uvtg_pkg::CLOCK_W];
        end
        if (advance)
        begin
            out_result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_result_reg.issued;
    assign m_tdata  = {out_result_reg.node_out,
                       out_result_reg.clock_seq_low,
                       out_result_reg.clock_seq_high_variant,
                       out_result_reg.time_high_version,
                       out_result_reg.time_mid,
                       out_result_reg.time_low};

endmodule

`default_nettype wire

// ===== bench/uuid_v1_time_generator_core_tb.sv =====
// self-checking bench for the time-based uuid generator: directed table, then random phases
module uuid_v1_time_generator_core_tb;

    typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

    // one directed step: a request (val = clock_now) or a register write (val = data)
    typedef struct packed {
        row_kind_t   kind;
        logic        reg_sel;
        logic [63:0] val;
        logic [15:0] rnd;
        logic        refusal;
    } plan_row_t;

    localparam logic [59:0] CLOCK_MAX = {uvtg_pkg::CLOCK_W{1'b1}};
    localparam logic [47:0] NODE_MAX  = {uvtg_pkg::NODE_W{1'b1}};
    localparam logic [23:0] TICK_MAX  = {uvtg_pkg::TICK_W{1'b1}};

    localparam plan_row_t PLAN [25] = '{
        '{ROW_ITEM,  1'b0, 64'd5,                16'h1234, 1'b1}, // priming
        '{ROW_ITEM,  1'b0, 64'd5,                16'h0000, 1'b1}, // saturated after priming
        '{ROW_ITEM,  1'b0, 64'd0,                16'hffff, 1'b0},
        '{ROW_ITEM,  1'b0, {4'b0, CLOCK_MAX},    16'h0000, 1'b0},
        '{ROW_ITEM,  1'b0, {4'b0, CLOCK_MAX},    16'h0000, 1'b0}, // stamp crosses 2^60
        '{ROW_ITEM,  1'b0, 64'd7,                16'h0000, 1'b0}, // backwards, sequence wraps
        '{ROW_WRITE, uvtg_pkg::REG_NODE_ID, {16'b0, NODE_MAX}, 16'h0000, 1'b0},
        '{ROW_ITEM,  1'b0, 64'd7,                16'ha5c3, 1'b0}, // node changed
        '{ROW_WRITE, uvtg_pkg::REG_MAX_PER_TICK, 64'd0, 16'h0000, 1'b0},
        '{ROW_ITEM,  1'b0, 64'd7,                16'h0000, 1'b1},
        '{ROW_ITEM,  1'b0, 64'd8,                16'h0000, 1'b0},
        '{ROW_ITEM,  1'b0, 64'd8,                16'h0000, 1'b1},
        '{ROW_WRITE, uvtg_pkg::REG_MAX_PER_TICK, 64'd3, 16'h0000, 1'b0},
        '{ROW_ITEM,  1'b0, 64'd20,               16'h0001, 1'b0},
        '{ROW_ITEM,  1'b0, 64'd20,               16'h0002, 1'b0},
        '{ROW_ITEM,  1'b0, 64'd20,               16'h0003, 1'b0},
        '{ROW_ITEM,  1'b0, 64'd20,               16'h0004, 1'b0},
        '{ROW_ITEM,  1'b0, 64'd20,               16'h0005, 1'b1},
        '{ROW_WRITE, uvtg_pkg::REG_MAX_PER_TICK, 64'd1, 16'h0000, 1'b0}, // limit below count
        '{ROW_ITEM,  1'b0, 64'd20,               16'h0006, 1'b1},
        '{ROW_WRITE, uvtg_pkg::REG_MAX_PER_TICK, {40'b0, TICK_MAX}, 16'h0000, 1'b0},
        '{ROW_ITEM,  1'b0, 64'd20,               16'h0007, 1'b0},
        '{ROW_WRITE, uvtg_pkg::REG_NODE_ID, 64'd0, 16'h0000, 1'b0},
        '{ROW_ITEM,  1'b0, 64'h0aaa_aaaa_aaaa_aaaa, 16'h5555, 1'b0},
        '{ROW_ITEM,  1'b0, 64'h0555_5555_5555_5555, 16'haaaa, 1'b0}
    };

    logic                            clk;
    logic                            rst_n;
    logic [uvtg_pkg::IN_DATA_W-1:0]  s_tdata;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [uvtg_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                            m_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [uvtg_pkg::APB_ADDR_W-1:0] paddr;
    logic [uvtg_pkg::APB_DATA_W-1:0] pwdata;
    logic [uvtg_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    uuid_v1_time_generator_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // generator state as the block should hold it
    logic              gen_primed;
    logic [59:0]       prev_clock;
    logic [23:0]       ticks_in_clock;
    logic              seq_valid;
    logic [63:0]       prev_stamp;
    logic [15:0]       prev_seq;
    logic [47:0]       prev_node;
    logic [47:0]       cfg_node;
    logic [23:0]       cfg_tick_limit;

    uvtg_pkg::result_t pending_uuids[$];
    int                errors;
    int                items_sent;
    int                send_idle_pct;
    int                recv_idle_pct;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    initial
    begin
        #4800000;
        $display("uuid_v1_time_generator_core: mismatch");
        $finish;
    end

    function automatic uvtg_pkg::result_t issue_uuid(input logic [59:0] now,
                                                     input logic [15:0] rnd);
        uvtg_pkg::result_t r;
        logic [63:0]       stamp;
        logic [15:0]       seq;
        r = '0;
        if (!gen_primed)
        begin
            gen_primed     = 1'b1;
            prev_clock     = now;
            ticks_in_clock = cfg_tick_limit;
            return r;
        end
        if (now != prev_clock)
        begin
            prev_clock     = now;
            ticks_in_clock = '0;
        end
        else if (ticks_in_clock < cfg_tick_limit)
            ticks_in_clock = ticks_in_clock + 24'd1;
        else
            return r;
        stamp = {4'b0, now} + {40'b0, ticks_in_clock};
        if (!seq_valid || prev_node != cfg_node)
        begin
            seq       = rnd;
            seq_valid = 1'b1;
        end
        else
        begin
            seq = prev_seq;
            if (stamp < prev_stamp)
                seq = seq + 16'd1;
        end
        prev_stamp = stamp;
        prev_seq   = seq;
        prev_node  = cfg_node;
        r.issued                 = 1'b1;
        r.time_low               = stamp[31:0];
        r.time_mid               = stamp[47:32];
        r.time_high_version      = {uvtg_pkg::UUID_VERSION, stamp[59:48]};
        r.clock_seq_high_variant = {uvtg_pkg::UUID_VARIANT, seq[13:8]};
        r.clock_seq_low          = seq[7:0];
        r.node_out               = cfg_node;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t %s: expected %h, got %h", $time, name, want, got);
        end
    endtask

    // sender side: optional gap, then hold the item until accepted
    task automatic send_request(input logic [59:0] now, input logic [15:0] rnd,
                                input logic refusal);
        uvtg_pkg::result_t want;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tdata  <= {4'b0, rnd, now};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        want = issue_uuid(now, rnd);
        // refusal rows carry a result known up front: all fields zero
        if (refusal)
            want = '0;
        pending_uuids.push_back(want);
        items_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_uuids.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // write then read back; the read setup follows the write access directly
    task automatic reg_write(input logic reg_sel, input logic [63:0] val);
        logic [63:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 3'b000};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (reg_sel == uvtg_pkg::REG_NODE_ID)
        begin
            cfg_node = val[47:0];
            want     = {16'b0, cfg_node};
        end
        else
        begin
            cfg_tick_limit = val[23:0];
            want           = {40'b0, cfg_tick_limit};
        end
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        check_field(reg_sel == uvtg_pkg::REG_NODE_ID ? "node_id read" : "max_per_tick read",
                    want, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // receiver: random stalls plus one long hold-off while the sender keeps going
    initial
    begin : sink
        int hold;
        bit pressure_done;
        hold          = 0;
        pressure_done = 0;
        m_tready      = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!pressure_done && items_sent >= 720)
            begin
                hold          = 80;
                pressure_done = 1;
            end
            if (hold > 0)
            begin
                hold--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : result_check
        uvtg_pkg::result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_uuids.size() == 0)
            begin
                errors++;
                $display("%0t unexpected item: expected none, got %h / %b",
                         $time, m_tdata, m_tuser);
            end
            else
            begin
                want = pending_uuids.pop_front();
                check_field("issued", 64'(want.issued), 64'(m_tuser));
                check_field("time_low", 64'(want.time_low), 64'(m_tdata[31:0]));
                check_field("time_mid", 64'(want.time_mid), 64'(m_tdata[47:32]));
                check_field("time_high_version", 64'(want.time_high_version),
                            64'(m_tdata[63:48]));
                check_field("clock_seq_high_variant", 64'(want.clock_seq_high_variant),
                            64'(m_tdata[71:64]));
                check_field("clock_seq_low", 64'(want.clock_seq_low), 64'(m_tdata[79:72]));
                check_field("node_out", 64'(want.node_out), 64'(m_tdata[127:80]));
            end
        end
    end

    initial
    begin : stimulus
        logic [59:0] cur_clock;
        logic [63:0] wide;
        int          pick;
        int          chunk;
        int          left;

        rst_n          = 1'b0;
        s_tdata        = '0;
        s_tvalid       = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        errors         = 0;
        items_sent     = 0;
        send_idle_pct  = 0;
        recv_idle_pct  = 0;
        gen_primed     = 1'b0;
        prev_clock     = '0;
        ticks_in_clock = '0;
        seq_valid      = 1'b0;
        prev_stamp     = '0;
        prev_seq       = '0;
        prev_node      = '0;
        cfg_node       = '0;
        cfg_tick_limit = uvtg_pkg::MAX_PER_TICK_RESET;
        cur_clock      = 60'd1000;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (PLAN[i])
        begin
            if (PLAN[i].kind == ROW_WRITE)
            begin
                wait_drained();
                reg_write(PLAN[i].reg_sel, PLAN[i].val);
            end
            else
                send_request(PLAN[i].val[59:0], PLAN[i].rnd, PLAN[i].refusal);
        end

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 28 : (ph == 1) ? 65 : 0;
            recv_idle_pct = (ph == 0) ? 65 : (ph == 1) ? 28 : 0;
            left = 334;
            while (left > 0)
            begin
                // new settings between chunks, only once the block is empty
                wait_drained();
                pick = $urandom_range(0, 5);
                if (pick == 0)
                    reg_write(uvtg_pkg::REG_NODE_ID, 64'd0);
                else if (pick == 1)
                    reg_write(uvtg_pkg::REG_NODE_ID, {16'b0, NODE_MAX});
                else if (pick == 2)
                    reg_write(uvtg_pkg::REG_NODE_ID,
                              {16'b0, 16'($urandom_range(0, 65535)), $urandom()});
                pick = $urandom_range(0, 9);
                if (pick < 5)
                    reg_write(uvtg_pkg::REG_MAX_PER_TICK, 64'($urandom_range(0, 4)));
                else if (pick == 5)
                    reg_write(uvtg_pkg::REG_MAX_PER_TICK, 64'd0);
                else if (pick == 6)
                    reg_write(uvtg_pkg::REG_MAX_PER_TICK, {40'b0, TICK_MAX});
                else if (pick == 7)
                    reg_write(uvtg_pkg::REG_MAX_PER_TICK,
                              {40'b0, uvtg_pkg::MAX_PER_TICK_RESET});
                else
                    reg_write(uvtg_pkg::REG_MAX_PER_TICK,
                              64'($urandom_range(0, 24'hffffff)));
                chunk = $urandom_range(25, 50);
                if (chunk > left)
                    chunk = left;
                left -= chunk;
                repeat (chunk)
                begin
                    // mostly repeats and small steps so tick counting and saturation are hit
                    pick = $urandom_range(0, 99);
                    if (pick < 40)
                        cur_clock = cur_clock;
                    else if (pick < 70)
                        cur_clock = cur_clock + 60'($urandom_range(1, 3));
                    else if (pick < 80)
                        cur_clock = cur_clock - 60'($urandom_range(1, 3));
                    else if (pick < 93)
                    begin
                        wide      = {$urandom(), $urandom()};
                        cur_clock = wide[59:0];
                    end
                    else
                        cur_clock = CLOCK_MAX - 60'($urandom_range(0, 2));
                    send_request(cur_clock, 16'($urandom_range(0, 65535)), 1'b0);
                end
            end
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (errors == 0 && pending_uuids.size() == 0)
            $display("uuid_v1_time_generator_core: match");
        else
            $display("uuid_v1_time_generator_core: mismatch");
        $finish;
    end

endmodule
